[hdl/vtp_pkg.sv]
`default_nettype none
package vtp_pkg;

   // field widths
   localparam int DIM_W     = 13;
   localparam int COORD_W   = 12;
   localparam int COMP_W    = 8;
   localparam int MODE_W    = 3;
   localparam int NUM_W     = COMP_W + COORD_W;  // component times coordinate
   localparam int LANES     = 3;                 // red, green, blue
   localparam int DIV_STEPS = NUM_W;             // one quotient bit per stage
   localparam int RAD_W     = DIM_W - 2;
   localparam int SQ_W      = 2 * DIM_W - 1;
   localparam int RSQ_W     = 2 * RAD_W;

   // register port
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // dimensions above this are saturated
   localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(4096);

   localparam logic [DIM_W-1:0]  RESET_DIM  = DIM_W'(256);
   localparam logic [COMP_W-1:0] COMP_MAX   = {COMP_W{1'b1}};
   localparam logic [COMP_W-1:0] RESET_COMP = '0;
   localparam logic [MODE_W-1:0] RESET_MODE = '0;

   typedef logic [COMP_W-1:0] comp_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_SOLID   = 3'd0,
      MODE_CHECKER = 3'd1,
      MODE_HGRAD   = 3'd2,
      MODE_VGRAD   = 3'd3,
      MODE_DISC    = 3'd4,
      MODE_STRIPES = 3'd5
   } mode_type;

   typedef enum logic [ADDR_W-3:0] {
      REG_WIDTH  = 3'd0,
      REG_HEIGHT = 3'd1,
      REG_RED    = 3'd2,
      REG_GREEN  = 3'd3,
      REG_BLUE   = 3'd4,
      REG_MODE   = 3'd5
   } reg_type;

   // configuration as seen by the datapath (dimensions already clamped)
   typedef struct packed {
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      comp_type          red;
      comp_type          green;
      comp_type          blue;
      logic [MODE_W-1:0] mode;
   } cfg_type;

   // disc geometry and invert flag handed to the shape pipeline
   typedef struct packed {
      logic signed [DIM_W-1:0] dx;
      logic signed [DIM_W-1:0] dy;
      logic [RAD_W-1:0]        rad;
      logic                    invert;
   } shape_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      return (d > MAX_DIM) ? MAX_DIM : d;
   endfunction

endpackage
`default_nettype wire

[hdl/vtp_req_if.sv]
`default_nettype none
interface vtp_req_if;
   logic                         valid;
   logic                         ready;
   logic [vtp_pkg::COORD_W-1:0]  pixel_x;
   logic [vtp_pkg::COORD_W-1:0]  pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface
`default_nettype wire

[hdl/vtp_rsp_if.sv]
`default_nettype none
interface vtp_rsp_if;
   logic                valid;
   logic                ready;
   vtp_pkg::comp_type   out_red;
   vtp_pkg::comp_type   out_green;
   vtp_pkg::comp_type   out_blue;

   modport source (output valid, output out_red, output out_green, output out_blue,
                   input ready);
   modport sink   (input valid, input out_red, input out_green, input out_blue,
                   output ready);
endinterface
`default_nettype wire

[hdl/vtp_csr.sv]
`default_nettype none
module vtp_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [vtp_pkg::ADDR_W-1:0]  paddr,
   input  logic [vtp_pkg::DATA_W-1:0]  pwdata,
   output logic [vtp_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output vtp_pkg::cfg_type            cfg
);

   logic [vtp_pkg::DIM_W-1:0]  width_ff,  width_in;
   logic [vtp_pkg::DIM_W-1:0]  height_ff, height_in;
   vtp_pkg::comp_type          red_ff,    red_in;
   vtp_pkg::comp_type          green_ff,  green_in;
   vtp_pkg::comp_type          blue_ff,   blue_in;
   logic [vtp_pkg::MODE_W-1:0] mode_ff,   mode_in;

   logic                           write_en;
   logic [vtp_pkg::ADDR_W-3:0]     index;

   assign pready   = 1'b1;
   assign write_en = psel & penable & pwrite;
   assign index    = paddr[vtp_pkg::ADDR_W-1:2];

   // register write decode; addresses past the list are dropped
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      red_in    = red_ff;
      green_in  = green_ff;
      blue_in   = blue_ff;
      mode_in   = mode_ff;
      if (write_en) begin
         case (index)
            vtp_pkg::REG_WIDTH:  width_in  = pwdata[vtp_pkg::DIM_W-1:0];
            vtp_pkg::REG_HEIGHT: height_in = pwdata[vtp_pkg::DIM_W-1:0];
            vtp_pkg::REG_RED:    red_in    = pwdata[vtp_pkg::COMP_W-1:0];
            vtp_pkg::REG_GREEN:  green_in  = pwdata[vtp_pkg::COMP_W-1:0];
            vtp_pkg::REG_BLUE:   blue_in   = pwdata[vtp_pkg::COMP_W-1:0];
            vtp_pkg::REG_MODE:   mode_in   = pwdata[vtp_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= vtp_pkg::RESET_DIM;
         height_ff <= vtp_pkg::RESET_DIM;
         red_ff    <= vtp_pkg::RESET_COMP;
         green_ff  <= vtp_pkg::RESET_COMP;
         blue_ff   <= vtp_pkg::RESET_COMP;
         mode_ff   <= vtp_pkg::RESET_MODE;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         red_ff    <= red_in;
         green_ff  <= green_in;
         blue_ff   <= blue_in;
         mode_ff   <= mode_in;
      end
   end

   // read back raw register values
   always_comb begin
      case (index)
         vtp_pkg::REG_WIDTH:  prdata = vtp_pkg::DATA_W'(width_ff);
         vtp_pkg::REG_HEIGHT: prdata = vtp_pkg::DATA_W'(height_ff);
         vtp_pkg::REG_RED:    prdata = vtp_pkg::DATA_W'(red_ff);
         vtp_pkg::REG_GREEN:  prdata = vtp_pkg::DATA_W'(green_ff);
         vtp_pkg::REG_BLUE:   prdata = vtp_pkg::DATA_W'(blue_ff);
         vtp_pkg::REG_MODE:   prdata = vtp_pkg::DATA_W'(mode_ff);
         default:             prdata = '0;
      endcase
   end

   // datapath view, dimensions saturated
   always_comb begin
      cfg.width  = vtp_pkg::clamp_dim(width_ff);
      cfg.height = vtp_pkg::clamp_dim(height_ff);
      cfg.red    = red_ff;
      cfg.green  = green_ff;
      cfg.blue   = blue_ff;
      cfg.mode   = mode_ff;
   end

endmodule
`default_nettype wire

[hdl/vtp_divider.sv]
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one divisor. Only the low byte of each quotient is kept.
module vtp_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic                        in_zero,
   input  logic [vtp_pkg::NUM_W-1:0]   in_num [vtp_pkg::LANES],
   input  logic [vtp_pkg::DIM_W-1:0]   divisor,
   output logic                        out_valid,
   output logic                        out_zero,
   output vtp_pkg::comp_type           out_quot [vtp_pkg::LANES]
);

   localparam int STEPS = vtp_pkg::DIV_STEPS;
   localparam int LN    = vtp_pkg::LANES;
   localparam int DW    = vtp_pkg::DIM_W;
   localparam int NW    = vtp_pkg::NUM_W;
   localparam int CW    = vtp_pkg::COMP_W;

   logic          valid_ff [STEPS];
   logic          zero_ff  [STEPS];
   logic [DW-1:0] rem_ff   [STEPS][LN];
   logic [NW-1:0] num_ff   [STEPS][LN];
   logic [CW-1:0] quot_ff  [STEPS][LN];

   logic [DW-1:0] rem_in   [STEPS][LN];
   logic [NW-1:0] num_in   [STEPS][LN];
   logic [CW-1:0] quot_in  [STEPS][LN];
   logic          valid_in [STEPS];
   logic          zero_in  [STEPS];

   genvar s, l;
   generate
      for (s = 0; s < STEPS; s++) begin : g_stage
         if (s == 0) begin : g_first
            assign valid_in[s] = in_valid;
            assign zero_in[s]  = in_zero;
         end else begin : g_next
            assign valid_in[s] = valid_ff[s-1];
            assign zero_in[s]  = zero_ff[s-1];
         end

         for (l = 0; l < LN; l++) begin : g_lane
            logic [DW-1:0] rem_src;
            logic [NW-1:0] num_src;
            logic [CW-1:0] quot_src;
            logic [DW:0]   trial;
            logic [DW:0]   diff;
            logic          qbit;

            if (s == 0) begin : g_src0
               assign rem_src  = '0;
               assign num_src  = in_num[l];
               assign quot_src = '0;
            end else begin : g_srcn
               assign rem_src  = rem_ff[s-1][l];
               assign num_src  = num_ff[s-1][l];
               assign quot_src = quot_ff[s-1][l];
            end

            // shift in next numerator bit, subtract when it fits
            assign trial = {rem_src, num_src[NW-1]};
            assign diff  = trial - {1'b0, divisor};
            assign qbit  = (trial >= {1'b0, divisor});

            assign rem_in[s][l]  = qbit ? diff[DW-1:0] : trial[DW-1:0];
            assign num_in[s][l]  = {num_src[NW-2:0], 1'b0};
            assign quot_in[s][l] = {quot_src[CW-2:0], qbit};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else if (adv) begin
               valid_ff[s] <= valid_in[s];
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               zero_ff[s] <= zero_in[s];
               for (int k = 0; k < LN; k++) begin
                  rem_ff[s][k]  <= rem_in[s][k];
                  num_ff[s][k]  <= num_in[s][k];
                  quot_ff[s][k] <= quot_in[s][k];
               end
            end
         end
      end

      for (l = 0; l < LN; l++) begin : g_out
         assign out_quot[l] = quot_ff[STEPS-1][l];
      end
   endgenerate

   assign out_valid = valid_ff[STEPS-1];
   assign out_zero  = zero_ff[STEPS-1];

endmodule
`default_nettype wire

[hdl/vtp_shape.sv]
`default_nettype none
// Disc membership test plus invert flag, delayed to line up with the divider.
module vtp_shape (
   input  logic                clock,
   input  logic                adv,
   input  vtp_pkg::shape_type  shape,
   output logic                in_disc,
   output logic                invert
);

   localparam int DW    = vtp_pkg::DIM_W;
   localparam int SW    = vtp_pkg::SQ_W;
   localparam int RW    = vtp_pkg::RSQ_W;
   localparam int DEPTH = vtp_pkg::DIV_STEPS - 1;

   logic [SW-1:0]   dx2_ff, dx2_in;
   logic [SW-1:0]   dy2_ff, dy2_in;
   logic [RW-1:0]   rad2_ff, rad2_in;
   logic            inv1_ff;

   logic signed [2*DW-1:0] dx_sq;
   logic signed [2*DW-1:0] dy_sq;
   logic [SW:0]            dist_sq;
   logic [1:0]             line_ff [DEPTH];
   logic [1:0]             line_in;

   // squares
   assign dx_sq   = (2*DW)'($signed(shape.dx)) * (2*DW)'($signed(shape.dx));
   assign dy_sq   = (2*DW)'($signed(shape.dy)) * (2*DW)'($signed(shape.dy));
   assign dx2_in  = dx_sq[SW-1:0];
   assign dy2_in  = dy_sq[SW-1:0];
   assign rad2_in = RW'(shape.rad) * RW'(shape.rad);

   always_ff @(posedge clock) begin
      if (adv) begin
         dx2_ff  <= dx2_in;
         dy2_ff  <= dy2_in;
         rad2_ff <= rad2_in;
         inv1_ff <= shape.invert;
      end
   end

   // strict compare of squared distance against squared radius
   assign dist_sq = {1'b0, dx2_ff} + {1'b0, dy2_ff};
   assign line_in = {(dist_sq < (SW+1)'(rad2_ff)), inv1_ff};

   // delay line
   always_ff @(posedge clock) begin
      if (adv) begin
         line_ff[0] <= line_in;
         for (int k = 1; k < DEPTH; k++) begin
            line_ff[k] <= line_ff[k-1];
         end
      end
   end

   assign in_disc = line_ff[DEPTH-1][1];
   assign invert  = line_ff[DEPTH-1][0];

endmodule
`default_nettype wire

[hdl/video_test_pattern_pixel.sv]
`default_nettype none
// Channel   Dir   Handshake              Payload
// req       in    req.valid/req.ready    pixel_x[11:0], pixel_y[11:0]
// rsp       out   rsp.valid/rsp.ready    out_red, out_green, out_blue [7:0]
// csr       in    csr_psel/csr_penable   6 registers at byte address 4*i
//
// One pixel per clock sustained. A pixel reaches rsp through one front stage
// (products and disc geometry), 20 divider stages (one quotient bit each) and
// one output register. Reset (synchronous) restores register defaults and
// clears all valid bits. While a result waits on rsp, the whole pipeline holds;
// nothing is dropped or repeated.
module video_test_pattern_pixel (
   input  logic                        clock,
   input  logic                        reset,
   vtp_req_if.sink                     req,
   vtp_rsp_if.source                   rsp,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [vtp_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [vtp_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [vtp_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   localparam int LN = vtp_pkg::LANES;
   localparam int DW = vtp_pkg::DIM_W;
   localparam int NW = vtp_pkg::NUM_W;

   vtp_pkg::cfg_type cfg;

   logic                 adv;
   logic                 a_valid_ff, a_valid_in;
   logic                 a_zero_ff,  a_zero_in;
   logic [NW-1:0]        a_num_ff [LN];
   logic [NW-1:0]        a_num_in [LN];
   vtp_pkg::shape_type   a_shape_ff, a_shape_in;

   vtp_pkg::comp_type    base [LN];
   logic [vtp_pkg::COORD_W-1:0] pos;
   logic [DW-1:0]        divisor;

   logic                 d_valid;
   logic                 d_zero;
   vtp_pkg::comp_type    d_quot [LN];
   logic                 s_inside;
   logic                 s_invert;

   logic                 out_valid_ff, out_valid_in;
   vtp_pkg::comp_type    out_ff [LN];
   vtp_pkg::comp_type    out_in [LN];

   vtp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // global advance: move when the output register is free or being drained
   assign adv       = !out_valid_ff || rsp.ready;
   assign req.ready = adv;

   assign base[0] = cfg.red;
   assign base[1] = cfg.green;
   assign base[2] = cfg.blue;

   // gradient operand select
   assign pos     = (cfg.mode == vtp_pkg::MODE_VGRAD) ? req.pixel_y : req.pixel_x;
   assign divisor = (cfg.mode == vtp_pkg::MODE_VGRAD) ? cfg.height : cfg.width;

   // front stage
   always_comb begin
      a_valid_in = req.valid;
      a_zero_in  = (divisor == '0);
      for (int k = 0; k < LN; k++) begin
         a_num_in[k] = NW'(base[k]) * NW'(pos);
      end
      a_shape_in.dx  = $signed({1'b0, req.pixel_x}) - $signed({1'b0, cfg.width[DW-1:1]});
      a_shape_in.dy  = $signed({1'b0, req.pixel_y}) - $signed({1'b0, cfg.height[DW-1:1]});
      a_shape_in.rad = cfg.width[DW-1:2];
      case (cfg.mode)
         vtp_pkg::MODE_CHECKER: a_shape_in.invert = req.pixel_x[5] ^ req.pixel_y[5];
         vtp_pkg::MODE_STRIPES: a_shape_in.invert = req.pixel_x[4];
         default:               a_shape_in.invert = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_zero_ff  <= a_zero_in;
         a_shape_ff <= a_shape_in;
         for (int k = 0; k < LN; k++) begin
            a_num_ff[k] <= a_num_in[k];
         end
      end
   end

   vtp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (a_valid_ff),
      .in_zero   (a_zero_ff),
      .in_num    (a_num_ff),
      .divisor   (divisor),
      .out_valid (d_valid),
      .out_zero  (d_zero),
      .out_quot  (d_quot)
   );

   vtp_shape u_shape (
      .clock   (clock),
      .adv     (adv),
      .shape   (a_shape_ff),
      .in_disc (s_inside),
      .invert  (s_invert)
   );

   // final color select
   always_comb begin
      out_valid_in = d_valid;
      for (int k = 0; k < LN; k++) begin
         case (cfg.mode)
            vtp_pkg::MODE_HGRAD,
            vtp_pkg::MODE_VGRAD: out_in[k] = d_zero ? '0 : d_quot[k];
            vtp_pkg::MODE_DISC:  out_in[k] = s_inside ? vtp_pkg::COMP_MAX : base[k];
            default:             out_in[k] = base[k];
         endcase
         if (s_invert) begin
            out_in[k] = vtp_pkg::COMP_MAX - out_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < LN; k++) begin
            out_ff[k] <= out_in[k];
         end
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.out_red   = out_ff[0];
   assign rsp.out_green = out_ff[1];
   assign rsp.out_blue  = out_ff[2];

endmodule
`default_nettype wire
